// ===== rtl/dsl_text_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer checker.
// No dependencies.
`ifndef DSL_TEXT_TOKENIZER_ASSERT_SVH
`define DSL_TEXT_TOKENIZER_ASSERT_SVH
// Check a property on every rising clock edge outside reset.
`define DTT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a valid, stalled output beat holds its payload in the next cycle.
`define DTT_ASSERT_HOLD(label, vld, stl, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && stl) |=> (vld && $stable(sig))) else $error(msg);
`endif

// ===== rtl/dtt_pkg.sv =====
// Types and constants for the text tokenizer.
// No dependencies.
package dtt_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_DOT, M_FRAC, M_EXP, M_ESIGN, M_EDIG,
        M_LEADDOT, M_MINUS, M_SLASH, M_COMMENT
    } scan_mode_t;

    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_NUMBER  = 6'd1;
    localparam logic [5:0] K_KW0     = 6'd2;
    localparam logic [5:0] K_COMMENT = 6'd24;
    localparam logic [5:0] K_ARROW   = 6'd25;
    localparam logic [5:0] K_END     = 6'd36;
    localparam logic [5:0] K_EQ      = 6'd26;
    localparam logic [5:0] K_LPAREN  = 6'd27;
    localparam logic [5:0] K_RPAREN  = 6'd28;
    localparam logic [5:0] K_LBRACE  = 6'd29;
    localparam logic [5:0] K_RBRACE  = 6'd30;
    localparam logic [5:0] K_LBRACK  = 6'd31;
    localparam logic [5:0] K_RBRACK  = 6'd32;
    localparam logic [5:0] K_COMMA   = 6'd33;
    localparam logic [5:0] K_SEMI    = 6'd34;
    localparam logic [5:0] K_COLON   = 6'd35;

    localparam int NUM_KW = 22;
    localparam int KW_CHARS = 16;
    localparam logic [15:0] LEN_TOP = 16'hFFFF;

    // Keywords, first letter in the low byte, zero padded.
    typedef logic [KW_CHARS*8-1:0] kw_text_t;

    function automatic kw_text_t kw_text(input int i);
        kw_text_t t;
        t = '0;
        case (i)
            0:  t[63:0] = {"rotcesib"};
            1:  t[63:0] = {"diortnec"};
            2:  t[47:0] = {"elcric"};
            3:  t[95:0] = {"retnecmucric"};
            4:  t[79:0] = {"tniartsnoc"};
            5:  t[23:0] = {"xif"};
            6:  t[31:0] = {"eerf"};
            7:  t[63:0] = {"retnecni"};
            8:  t[71:0] = {"tcesretni"};
            9:  t[23:0] = {"tel"};
            10: t[31:0] = {"enil"};
            11: t[31:0] = {"daol"};
            12: t[63:0] = {"tniopdim"};
            13: t[87:0] = {"retnecohtro"};
            14: t[63:0] = {"lellarap"};
            15: t[103:0] = {"ralucidneprep"};
            16: t[39:0] = {"tniop"};
            17: t[55:0] = {"nogylop"};
            18: t[39:0] = {"evorp"};
            19: t[23:0] = {"yar"};
            20: t[55:0] = {"tnemges"};
            default: t[63:0] = {"elgnairt"};
        endcase
        return t;
    endfunction

    function automatic logic [4:0] kw_len(input int i);
        case (i)
            0, 1, 7, 12, 14, 21: return 5'd8;
            2:                   return 5'd6;
            3:                   return 5'd12;
            4:                   return 5'd10;
            5, 9, 19:            return 5'd3;
            6, 10, 11:           return 5'd4;
            8:                   return 5'd9;
            13:                  return 5'd11;
            15:                  return 5'd13;
            16, 18:              return 5'd5;
            default:             return 5'd7;
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
    endfunction

    // Punctuator kind, or K_IDENT when the byte is no punctuator.
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        case (c)
            "=":     return K_EQ;
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            "[":     return K_LBRACK;
            "]":     return K_RBRACK;
            ",":     return K_COMMA;
            ";":     return K_SEMI;
            ":":     return K_COLON;
            default: return K_IDENT;
        endcase
    endfunction

    // One classified byte from the front end.
    typedef struct packed {
        logic [7:0] ch;
        logic       has_char;
        logic       end_of_text;
    } beat_t;

endpackage

// ===== rtl/dtt_fifo.sv =====
// Short queue between the front end and the scanner.
// Depends on dtt_pkg.
module dtt_fifo
    import dtt_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  beat_t wr_data,
    output logic  full,
    input  logic  rd_en,
    output beat_t rd_data,
    output logic  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    beat_t           mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]     cnt_reg, cnt_next;

    assign full    = cnt_reg == (AW+1)'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr_en)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (rd_en)
        begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end
endmodule

// ===== rtl/dtt_scan.sv =====
// Scanner back end: token state machine, position counters, result sequencing.
// Depends on dtt_pkg.
module dtt_scan
    import dtt_pkg::*;
#(
    parameter int LINE_BITS = 16,
    parameter int COL_BITS = 16,
    parameter int POS_BITS = 24,
    parameter int MAX_KEYWORD_LEN = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  beat_t       in_beat,
    input  logic        in_avail,
    output logic        in_take,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [15:0] token_line,
    output logic [15:0] token_col,
    output logic [23:0] span_start,
    output logic [15:0] span_length,
    output logic        last_of_run
);
    localparam logic [LINE_BITS-1:0] LINE_TOP = '1;
    localparam logic [COL_BITS-1:0]  COL_TOP  = '1;
    localparam logic [POS_BITS-1:0]  POS_TOP  = '1;
    localparam int WL_BITS = $clog2(MAX_KEYWORD_LEN + 2);

    typedef struct packed {
        logic [5:0]           kind;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
        logic [POS_BITS-1:0]  pos;
        logic [15:0]          len;
    } tok_t;

    scan_mode_t           mode_reg, mode_next;
    logic [7:0]           wbuf_reg [MAX_KEYWORD_LEN];
    logic [WL_BITS-1:0]   wlen_reg, wlen_next;
    logic [LINE_BITS-1:0] line_reg, line_next, sline_reg, sline_next;
    logic [COL_BITS-1:0]  col_reg, col_next, scol_reg, scol_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next, spos_reg, spos_next;
    logic [15:0]          tlen_reg, tlen_next;
    logic                 seen_reg, seen_next;

    // Up to three results of one beat, drained from this buffer.
    tok_t                 res_reg [3];
    tok_t                 res_next [3];
    logic [1:0]           rcnt_reg, rcnt_next, ridx_reg, ridx_next;
    logic [1:0]           n;
    logic                 wr_buf, wr_ch;
    logic [WL_BITS-1:0]   wr_idx;

    logic [7:0] c;
    logic       has, eot;
    logic [5:0] word_kind;

    assign c   = in_beat.ch;
    assign has = in_beat.has_char;
    assign eot = in_beat.end_of_text;

    // Parallel keyword compare on the stored letters.
    always_comb
    begin
        kw_text_t w;
        w = '0;
        for (int i = 0; i < MAX_KEYWORD_LEN; i++)
        begin
            if (i < KW_CHARS && WL_BITS'(i) < wlen_reg)
            begin
                w[i*8 +: 8] = wbuf_reg[i];
            end
        end
        word_kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (WL_BITS'(kw_len(k)) == wlen_reg && w == kw_text(k))
            begin
                word_kind = K_KW0 + 6'(k);
            end
        end
    end

    // Word that the end beat flushes: the stored letters with this beat's byte applied.
    logic               wext;
    logic [WL_BITS-1:0] flush_len;
    logic [5:0]         flush_kind;

    assign wext = has && mode_reg == M_IDENT && (is_word_start(c) || is_digit(c));

    always_comb
    begin
        flush_len = wlen_reg;
        if (wext)
        begin
            if (wlen_reg <= WL_BITS'(MAX_KEYWORD_LEN)) flush_len = wlen_reg + 1'b1;
        end
        else if (has) flush_len = WL_BITS'(1);
    end

    always_comb
    begin
        kw_text_t w;
        w = '0;
        for (int i = 0; i < MAX_KEYWORD_LEN; i++)
        begin
            if (i < KW_CHARS && WL_BITS'(i) < flush_len)
            begin
                if (has && WL_BITS'(i) == (wext ? wlen_reg : '0))
                    w[i*8 +: 8] = c;
                else
                    w[i*8 +: 8] = wbuf_reg[i];
            end
        end
        flush_kind = K_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (WL_BITS'(kw_len(k)) == flush_len && w == kw_text(k))
            begin
                flush_kind = K_KW0 + 6'(k);
            end
        end
    end

    logic busy;
    assign busy      = rcnt_reg != ridx_reg;
    assign out_valid = busy;
    assign in_take   = in_avail && (!busy || (!out_stall && ridx_reg + 2'd1 == rcnt_reg));

    always_comb
    begin
        tok_t cur_tok;
        logic do_fresh;
        mode_next  = mode_reg;
        wlen_next  = wlen_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        pos_next   = pos_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;
        spos_next  = spos_reg;
        tlen_next  = tlen_reg;
        seen_next  = seen_reg;
        res_next   = res_reg;
        n          = 2'd0;
        wr_ch      = 1'b0;
        wr_idx     = '0;
        do_fresh   = 1'b0;
        cur_tok    = '{kind: K_IDENT, line: sline_reg, col: scol_reg, pos: spos_reg,
                       len: tlen_reg};
        wr_buf     = 1'b0;

        if (has)
        begin
            seen_next = 1'b1;
            unique case (mode_reg)
                M_COMMENT:
                begin
                    if (c == 8'h0A)
                    begin
                        cur_tok.kind = K_COMMENT;
                        res_next[n] = cur_tok; n = n + 2'd1;
                        do_fresh = 1'b1;
                    end
                    else if (tlen_reg != LEN_TOP) tlen_next = tlen_reg + 16'd1;
                end
                M_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode_next = M_COMMENT;
                        if (tlen_reg != LEN_TOP) tlen_next = tlen_reg + 16'd1;
                    end
                    else do_fresh = 1'b1;
                end
                M_MINUS:
                begin
                    if (c == ">")
                    begin
                        cur_tok.kind = K_ARROW;
                        cur_tok.len  = (tlen_reg != LEN_TOP) ? tlen_reg + 16'd1 : LEN_TOP;
                        res_next[n] = cur_tok; n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else do_fresh = 1'b1;
                end
                M_IDENT:
                begin
                    if (is_word_start(c) || is_digit(c))
                    begin
                        if (wlen_reg < WL_BITS'(MAX_KEYWORD_LEN))
                        begin
                            wr_ch  = 1'b1;
                            wr_idx = wlen_reg;
                        end
                        if (wlen_reg <= WL_BITS'(MAX_KEYWORD_LEN))
                            wlen_next = wlen_reg + 1'b1;
                        if (tlen_reg != LEN_TOP) tlen_next = tlen_reg + 16'd1;
                    end
                    else
                    begin
                        cur_tok.kind = word_kind;
                        res_next[n] = cur_tok; n = n + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_INT, M_FRAC:
                begin
                    if (is_digit(c))
                    begin
                        if (tlen_reg != LEN_TOP) tlen_next = tlen_reg + 16'd1;
                    end
                    else if (c == "." && mode_reg == M_INT) mode_next = M_DOT;
                    else if (c == "e" || c == "E")
                    begin
                        if (tlen_reg != LEN_TOP) tlen_next = tlen_reg + 16'd1;
                        mode_next = M_EXP;
                    end
                    else
                    begin
                        cur_tok.kind = K_NUMBER;
                        res_next[n] = cur_tok; n = n + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (is_digit(c))
                    begin
                        tlen_next = (tlen_reg >= LEN_TOP - 16'd1) ? LEN_TOP : tlen_reg + 16'd2;
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        cur_tok.kind = K_NUMBER;
                        res_next[n] = cur_tok; n = n + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_EXP, M_ESIGN, M_EDIG:
                begin
                    if (mode_reg == M_EXP && (c == "+" || c == "-"))
                    begin
                        if (tlen_reg != LEN_TOP) tlen_next = tlen_reg + 16'd1;
                        mode_next = M_ESIGN;
                    end
                    else if (is_digit(c))
                    begin
                        if (tlen_reg != LEN_TOP) tlen_next = tlen_reg + 16'd1;
                        mode_next = M_EDIG;
                    end
                    else
                    begin
                        cur_tok.kind = K_NUMBER;
                        res_next[n] = cur_tok; n = n + 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_LEADDOT:
                begin
                    if (is_digit(c))
                    begin
                        if (tlen_reg != LEN_TOP) tlen_next = tlen_reg + 16'd1;
                        mode_next = M_FRAC;
                    end
                    else do_fresh = 1'b1;
                end
                default: do_fresh = 1'b1;
            endcase

            if (do_fresh)
            begin
                mode_next = M_IDLE;
                if (c == "#" || c == "/" || c == "-" || c == "." || is_digit(c)
                    || is_word_start(c))
                begin
                    spos_next  = pos_reg;
                    sline_next = line_reg;
                    scol_next  = col_reg;
                    tlen_next  = 16'd1;
                    if (c == "#") mode_next = M_COMMENT;
                    else if (c == "/") mode_next = M_SLASH;
                    else if (c == "-") mode_next = M_MINUS;
                    else if (c == ".") mode_next = M_LEADDOT;
                    else if (is_digit(c)) mode_next = M_INT;
                    else
                    begin
                        mode_next = M_IDENT;
                        wr_ch     = 1'b1;
                        wr_idx    = '0;
                        wlen_next = WL_BITS'(1);
                    end
                end
                else if (punct_kind(c) != K_IDENT)
                begin
                    res_next[n] = '{kind: punct_kind(c), line: line_reg, col: col_reg,
                                    pos: pos_reg, len: 16'd1};
                    n = n + 2'd1;
                end
            end

            if (pos_reg != POS_TOP) pos_next = pos_reg + 1'b1;
            if (c == 8'h0A)
            begin
                if (line_reg != LINE_TOP) line_next = line_reg + 1'b1;
                col_next = COL_BITS'(1);
            end
            else if (col_reg != COL_TOP) col_next = col_reg + 1'b1;
        end

        if (eot)
        begin
            // Flush from the post-byte state.
            cur_tok = '{kind: K_NUMBER, line: sline_next, col: scol_next, pos: spos_next,
                        len: tlen_next};
            unique case (mode_next)
                M_COMMENT:
                begin
                    cur_tok.kind = K_COMMENT;
                    res_next[n] = cur_tok; n = n + 2'd1;
                end
                M_IDENT:
                begin
                    cur_tok.kind = flush_kind;
                    res_next[n] = cur_tok; n = n + 2'd1;
                end
                M_INT, M_DOT, M_FRAC, M_EXP, M_ESIGN, M_EDIG:
                begin
                    res_next[n] = cur_tok; n = n + 2'd1;
                end
                default: ;
            endcase
            if (seen_next)
            begin
                res_next[n] = '{kind: K_END, line: line_next, col: col_next, pos: pos_next,
                                len: 16'd0};
                n = n + 2'd1;
            end
            mode_next  = M_IDLE;
            wlen_next  = '0;
            line_next  = LINE_BITS'(1);
            col_next   = COL_BITS'(1);
            pos_next   = '0;
            sline_next = LINE_BITS'(1);
            scol_next  = COL_BITS'(1);
            spos_next  = '0;
            tlen_next  = '0;
            seen_next  = 1'b0;
        end
        wr_buf = 1'b1;
    end

    always_comb
    begin
        rcnt_next = rcnt_reg;
        ridx_next = ridx_reg;
        if (busy && !out_stall)
        begin
            ridx_next = ridx_reg + 2'd1;
        end
        if (in_take)
        begin
            rcnt_next = n;
            ridx_next = 2'd0;
        end
    end

    tok_t o;
    assign o = res_reg[ridx_reg];

    assign token_kind  = o.kind;
    assign token_line  = 16'(o.line);
    assign token_col   = 16'(o.col);
    assign span_start  = 24'(o.pos);
    assign span_length = o.len;
    assign last_of_run = ridx_reg + 2'd1 == rcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            wlen_reg  <= '0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= COL_BITS'(1);
            pos_reg   <= '0;
            sline_reg <= LINE_BITS'(1);
            scol_reg  <= COL_BITS'(1);
            spos_reg  <= '0;
            tlen_reg  <= '0;
            seen_reg  <= 1'b0;
            rcnt_reg  <= '0;
            ridx_reg  <= '0;
        end
        else
        begin
            rcnt_reg <= rcnt_next;
            ridx_reg <= ridx_next;
            if (in_take)
            begin
                mode_reg  <= mode_next;
                wlen_reg  <= wlen_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
                pos_reg   <= pos_next;
                sline_reg <= sline_next;
                scol_reg  <= scol_next;
                spos_reg  <= spos_next;
                tlen_reg  <= tlen_next;
                seen_reg  <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && wr_buf)
        begin
            res_reg <= res_next;
        end
        if (in_take && wr_ch)
        begin
            wbuf_reg[wr_idx[$clog2(MAX_KEYWORD_LEN)-1:0]] <= c;
        end
    end
endmodule

// ===== rtl/dtt_front.sv =====
// Front end: input handshake and decode of the beat into the queue.
// Depends on dtt_pkg.
module dtt_front
    import dtt_pkg::*;
(
    input  logic       ch_valid,
    output logic       ch_stall,
    input  logic [7:0] ch,
    input  logic       has_char,
    input  logic       end_of_text,
    input  logic       q_full,
    output logic       q_wr,
    output beat_t      q_data
);
    // Empty beats carry nothing and go no further.
    logic useful;
    assign useful   = has_char || end_of_text;
    assign ch_stall = q_full;
    assign q_wr     = ch_valid && !q_full && useful;
    assign q_data   = '{ch: ch, has_char: has_char, end_of_text: end_of_text};
endmodule

// ===== rtl/dsl_text_tokenizer.sv =====
// Top level of the text tokenizer: front end, queue and scanner.
// Depends on dtt_pkg, dtt_front, dtt_fifo, dtt_scan.
//
// Input channel (in_valid/in_stall): one beat per source byte (has_char=1),
// or a bare end marker (has_char=0, end_of_text=1). A beat with end_of_text
// flushes the pending token and adds an end token if any byte came since
// reset or the previous end. Beats with neither flag are dropped.
// Output channel (out_valid/out_stall): one beat per token; last_of_run marks
// the final token caused by an input beat.
// Throughput: one input beat per cycle while out_stall is low and each beat
// yields at most one token; a beat that yields more tokens holds the scanner
// until the single output port has drained the result buffer.
// A token is emitted by the beat that ends it. An accepted beat is first
// registered in the queue; the token is offered the cycle after the scanner
// takes that beat from the queue.
// Reset clears the scan state and counters at once; no clearing pass.
// When out_stall is high the scanner holds its result and the two-entry
// queue fills, then in_stall rises.
module dsl_text_tokenizer
    import dtt_pkg::*;
#(
    parameter int LINE_BITS = 16,
    parameter int COL_BITS = 16,
    parameter int POS_BITS = 24,
    parameter int MAX_KEYWORD_LEN = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        has_char,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [15:0] token_line,
    output logic [15:0] token_col,
    output logic [23:0] span_start,
    output logic [15:0] span_length,
    output logic        last_of_run
);
    logic  q_full, q_wr, q_empty, q_rd;
    beat_t q_wdata, q_rdata;

    dtt_front u_front (
        .ch_valid    (in_valid),
        .ch_stall    (in_stall),
        .ch          (ch),
        .has_char    (has_char),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_wr        (q_wr),
        .q_data      (q_wdata)
    );

    dtt_fifo #(.DEPTH(2)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    dtt_scan #(
        .LINE_BITS       (LINE_BITS),
        .COL_BITS        (COL_BITS),
        .POS_BITS        (POS_BITS),
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_beat     (q_rdata),
        .in_avail    (!q_empty),
        .in_take     (q_rd),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .token_kind  (token_kind),
        .token_line  (token_line),
        .token_col   (token_col),
        .span_start  (span_start),
        .span_length (span_length),
        .last_of_run (last_of_run)
    );
endmodule

// ===== rtl/dtt_checker.sv =====
// Port-level checks for the text tokenizer, bound to the top level.
// Depends on dtt_pkg, dsl_text_tokenizer_assert.svh and dsl_text_tokenizer.
`include "dsl_text_tokenizer_assert.svh"
module dtt_checker
    import dtt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [5:0]  token_kind,
    input logic [15:0] span_length,
    input logic [15:0] token_line,
    input logic [15:0] token_col
);
    `DTT_ASSERT(a_kind_range, out_valid |-> token_kind <= K_END, "token kind out of range")
    `DTT_ASSERT(a_end_len, (out_valid && token_kind == K_END) |-> span_length == 16'd0,
        "end token with nonzero length")
    `DTT_ASSERT(a_pos_nz, out_valid |-> (token_line != 16'd0 || token_col != 16'd0),
        "token at line and column zero")
    `DTT_ASSERT_HOLD(a_hold_kind, out_valid, out_stall, token_kind, "stalled token changed")
endmodule

bind dsl_text_tokenizer dtt_checker u_dtt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .token_kind  (token_kind),
    .span_length (span_length),
    .token_line  (token_line),
    .token_col   (token_col)
);

// ===== bench/dsl_text_tokenizer_test.sv =====
// Self-checking bench for dsl_text_tokenizer: a directed table of source bytes, then random text.
// Tokens are predicted in-bench and compared beat by beat. Depends on dtt_pkg and the tokenizer RTL.
module dsl_text_tokenizer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import dtt_pkg::*;

    typedef struct {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [23:0] start;
        logic [15:0] len;
        logic        last;
    } token_t;

    typedef struct {
        logic [7:0] ch;
        logic       has;
        logic       eot;
        bit         chk;
        token_t     want;
    } src_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  ch = 8'd0;
    logic        has_char = 1'b0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        rx_stall = 1'b0;
    logic        hold_off = 1'b0;
    logic        out_stall;
    logic [5:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_col;
    logic [23:0] span_start;
    logic [15:0] span_length;
    logic        last_of_run;

    assign out_stall = rx_stall | hold_off;

    dsl_text_tokenizer dut (.*);

    always #5 clk = ~clk;

    int        errors = 0;
    int        beats_in = 0;
    bit        stim_done = 1'b0;
    int        quiet_cycles = 0;
    token_t    pending_tokens[$];
    src_beat_t stim[$];

    string kw_names[22] = '{"bisector", "centroid", "circle", "circumcenter", "constraint",
        "fix", "free", "incenter", "intersect", "let", "line", "load", "midpoint",
        "orthocenter", "parallel", "perpendicular", "point", "polygon", "prove", "ray",
        "segment", "triangle"};

    // Scanner state of the predictor
    scan_mode_t  lx_mode;
    logic [7:0]  lx_word[13];
    int          lx_wlen;
    logic [15:0] lx_line, lx_col, lx_sline, lx_scol, lx_tlen;
    logic [23:0] lx_pos, lx_spos;
    bit          lx_seen;
    token_t      lx_run[$];

    task automatic report(string what, token_t got, token_t want);
        $display("mismatch %s: got k=%0d l=%0d c=%0d s=%0d n=%0d e=%0d, %s",
            what, got.kind, got.line, got.col, got.start, got.len, got.last,
            $sformatf("want k=%0d l=%0d c=%0d s=%0d n=%0d e=%0d",
                want.kind, want.line, want.col, want.start, want.len, want.last));
        errors++;
    endtask

    task automatic lx_clear();
        lx_mode = M_IDLE;
        lx_wlen = 0;
        lx_line = 1; lx_col = 1; lx_pos = 0;
        lx_spos = 0; lx_sline = 1; lx_scol = 1;
        lx_seen = 0;
        lx_tlen = 0;
    endtask

    function automatic bit dig(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit wordc(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [5:0] punct_code(logic [7:0] c);
        case (c)
            "=": return K_EQ;
            "(": return K_LPAREN;
            ")": return K_RPAREN;
            "{": return K_LBRACE;
            "}": return K_RBRACE;
            "[": return K_LBRACK;
            "]": return K_RBRACK;
            ",": return K_COMMA;
            ";": return K_SEMI;
            ":": return K_COLON;
            default: return K_IDENT;
        endcase
    endfunction

    task automatic lx_emit(logic [5:0] k, logic [15:0] l, logic [15:0] c, logic [23:0] p,
                           logic [15:0] n);
        token_t t;
        t = '{k, l, c, p, n, 1'b0};
        if (lx_run.size() < 3) lx_run.push_back(t);
    endtask

    task automatic lx_emit_pending(logic [5:0] k);
        lx_emit(k, lx_sline, lx_scol, lx_spos, lx_tlen);
    endtask

    task automatic lx_grow(int n);
        lx_tlen = (int'(lx_tlen) + n > 65535) ? LEN_TOP : 16'(int'(lx_tlen) + n);
    endtask

    task automatic lx_emit_word();
        logic [5:0] k;
        bit hit;
        k = K_IDENT;
        if (lx_wlen <= 13) begin
            for (int i = 21; i >= 0; i--) begin
                hit = kw_names[i].len() == lx_wlen;
                for (int j = 0; j < lx_wlen && hit; j++)
                    if (kw_names[i][j] != lx_word[j]) hit = 0;
                if (hit) k = K_KW0 + 6'(i);
            end
        end
        lx_emit_pending(k);
    endtask

    task automatic lx_begin(scan_mode_t m);
        lx_spos = lx_pos; lx_sline = lx_line; lx_scol = lx_col;
        lx_tlen = 1;
        lx_mode = m;
    endtask

    task automatic lx_fresh(logic [7:0] c);
        lx_mode = M_IDLE;
        if (c == "#") lx_begin(M_COMMENT);
        else if (c == "/") lx_begin(M_SLASH);
        else if (c == "-") lx_begin(M_MINUS);
        else if (c == ".") lx_begin(M_LEADDOT);
        else if (dig(c)) lx_begin(M_INT);
        else if (wordc(c)) begin
            lx_begin(M_IDENT);
            lx_word[0] = c;
            lx_wlen = 1;
        end
        else if (punct_code(c) != K_IDENT) lx_emit(punct_code(c), lx_line, lx_col, lx_pos, 1);
    endtask

    task automatic lx_feed(logic [7:0] c);
        case (lx_mode)
            M_COMMENT:
                if (c == 8'h0A) begin lx_emit_pending(K_COMMENT); lx_fresh(c); end
                else lx_grow(1);
            M_SLASH:
                if (c == "/") begin lx_mode = M_COMMENT; lx_grow(1); end
                else lx_fresh(c);
            M_MINUS:
                if (c == ">") begin lx_grow(1); lx_emit_pending(K_ARROW); lx_mode = M_IDLE; end
                else lx_fresh(c);
            M_IDENT:
                if (wordc(c) || dig(c)) begin
                    if (lx_wlen < 13) lx_word[lx_wlen] = c;
                    if (lx_wlen <= 13) lx_wlen++;
                    lx_grow(1);
                end
                else begin lx_emit_word(); lx_fresh(c); end
            M_INT:
                if (dig(c)) lx_grow(1);
                else if (c == ".") lx_mode = M_DOT;
                else if (c == "e" || c == "E") begin lx_grow(1); lx_mode = M_EXP; end
                else begin lx_emit_pending(K_NUMBER); lx_fresh(c); end
            M_DOT:
                if (dig(c)) begin lx_grow(2); lx_mode = M_FRAC; end
                else begin lx_emit_pending(K_NUMBER); lx_fresh(c); end
            M_FRAC:
                if (dig(c)) lx_grow(1);
                else if (c == "e" || c == "E") begin lx_grow(1); lx_mode = M_EXP; end
                else begin lx_emit_pending(K_NUMBER); lx_fresh(c); end
            M_EXP:
                if (c == "+" || c == "-") begin lx_grow(1); lx_mode = M_ESIGN; end
                else if (dig(c)) begin lx_grow(1); lx_mode = M_EDIG; end
                else begin lx_emit_pending(K_NUMBER); lx_fresh(c); end
            M_ESIGN, M_EDIG:
                if (dig(c)) begin lx_grow(1); lx_mode = M_EDIG; end
                else begin lx_emit_pending(K_NUMBER); lx_fresh(c); end
            M_LEADDOT:
                if (dig(c)) begin lx_grow(1); lx_mode = M_FRAC; end
                else lx_fresh(c);
            default: lx_fresh(c);
        endcase
    endtask

    // Predict the tokens of one accepted beat and queue them.
    task automatic predict_tokens(src_beat_t b);
        lx_run.delete();
        if (b.has) begin
            lx_seen = 1;
            lx_feed(b.ch);
            if (lx_pos != 24'hFFFFFF) lx_pos++;
            if (b.ch == 8'h0A) begin
                if (lx_line != 16'hFFFF) lx_line++;
                lx_col = 1;
            end
            else if (lx_col != 16'hFFFF) lx_col++;
        end
        if (b.eot) begin
            case (lx_mode)
                M_COMMENT: lx_emit_pending(K_COMMENT);
                M_IDENT: lx_emit_word();
                M_INT, M_DOT, M_FRAC, M_EXP, M_ESIGN, M_EDIG: lx_emit_pending(K_NUMBER);
                default: ;
            endcase
            if (lx_seen) lx_emit(K_END, lx_line, lx_col, lx_pos, 0);
            lx_clear();
        end
        if (lx_run.size() > 0) lx_run[lx_run.size()-1].last = 1'b1;
        if (b.chk) begin
            if (lx_run.size() == 0) report("table row without token", b.want, b.want);
            else if (lx_run[0] != b.want) report("table row", lx_run[0], b.want);
        end
        foreach (lx_run[i]) pending_tokens.push_back(lx_run[i]);
    endtask

    task automatic add_beat(logic [7:0] c, logic h, logic e);
        stim.push_back('{c, h, e, 1'b0, '{default: '0}});
    endtask

    task automatic add_row(logic [7:0] c, logic h, logic e, token_t w);
        stim.push_back('{c, h, e, 1'b1, w});
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_beat(s[i], 1'b1, 1'b0);
    endtask

    task automatic build_random();
        string wchars, pchars;
        int bytes, n;
        wchars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        pchars = "=(){}[],;:";
        bytes = 0;
        while (bytes < 50) begin
            n = stim.size();
            case ($urandom_range(0, 11))
                0: add_text(kw_names[$urandom_range(0, 21)]);
                1: begin
                    add_beat(wchars[$urandom_range(0, 52)], 1, 0);
                    repeat ($urandom_range(0, 15)) add_beat(wchars[$urandom_range(0, 62)], 1, 0);
                end
                2: begin
                    repeat ($urandom_range(1, 3)) add_beat(8'("0" + $urandom_range(0, 9)), 1, 0);
                    if ($urandom_range(0, 1)) begin
                        add_beat(".", 1, 0);
                        repeat ($urandom_range(0, 2))
                            add_beat(8'("0" + $urandom_range(0, 9)), 1, 0);
                    end
                    if ($urandom_range(0, 1)) begin
                        add_beat($urandom_range(0, 1) ? "e" : "E", 1, 0);
                        if ($urandom_range(0, 1)) add_beat($urandom_range(0, 1) ? "+" : "-", 1, 0);
                        repeat ($urandom_range(0, 2))
                            add_beat(8'("0" + $urandom_range(0, 9)), 1, 0);
                    end
                end
                3: begin
                    add_text($urandom_range(0, 1) ? "#" : "//");
                    repeat ($urandom_range(0, 6)) add_beat(8'($urandom_range(32, 126)), 1, 0);
                    add_beat(8'h0A, 1, 0);
                end
                4: add_text("->");
                5: add_beat(pchars[$urandom_range(0, 9)], 1, 0);
                6: add_beat($urandom_range(0, 2) ? " " : 8'h0A, 1, 0);
                7: add_beat(8'($urandom_range(0, 255)), 1, 0);
                8: add_beat(8'($urandom_range(0, 255)), 0, 0);
                9: add_beat(8'($urandom_range(0, 255)), 0, 1);
                10: add_beat($urandom_range(0, 1) ? ";" : "7", 1, 1);
                default: add_beat($urandom_range(0, 2) == 0 ? "-" : ($urandom_range(0, 1) ? "/" : "."),
                                  1, 0);
            endcase
            if ($urandom_range(0, 3) != 0) add_beat(" ", 1, 0);
            for (int i = n; i < stim.size(); i++) if (stim[i].has) bytes++;
        end
        add_beat(8'h00, 0, 1);
    endtask

    // Directed table; typed tokens only where obvious
    task automatic build_table();
        add_row("(", 1, 0, '{K_LPAREN, 1, 1, 0, 1, 1});
        add_row(8'h00, 0, 1, '{K_END, 1, 2, 1, 0, 1});
        add_beat(8'hFF, 0, 1);                  // end with no byte: nothing
        add_beat(8'h00, 1, 0);
        add_beat(8'hFF, 1, 0);
        add_beat("#", 1, 0);
        add_row(8'h0A, 1, 0, '{K_COMMENT, 1, 3, 2, 1, 1});
        add_text("->/x//c");
        add_beat(8'h0A, 1, 0);
        add_text("5.x .7e-2 1E ");
        add_text("circumcenter perpendicular perpendicularx _Z9");
        add_beat(8'h0A, 1, 0);
        add_beat("9", 1, 0);
        add_beat(";", 1, 1);                    // number, punctuator and end on one beat
        add_beat("-", 1, 1);
    endtask

    // Sender
    initial begin
        src_beat_t b;
        int gap;
        bit calm;
        lx_clear();
        build_table();
        build_random();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        calm = 0;
        foreach (stim[i]) begin
            b = stim[i];
            if (i % 20 == 0) calm = $urandom_range(0, 1);
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            in_valid = 1'b1;
            ch = b.ch;
            has_char = b.has;
            end_of_text = b.eot;
            @(posedge clk);
            while (in_stall) @(posedge clk);
            beats_in++;
            predict_tokens(b);
        end
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_tokens.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // Receiver stall pattern
    initial begin
        int n;
        forever begin
            n = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            if (n > 0) begin
                @(negedge clk);
                rx_stall = 1'b1;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk);
            rx_stall = 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Long hold-off so the queue fills and the input stalls
    initial begin
        wait (beats_in >= 60);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
    end

    // Token checker
    always @(posedge clk) begin
        token_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{token_kind, token_line, token_col, span_start, span_length, last_of_run};
            if (pending_tokens.size() == 0) report("unexpected token", got, got);
            else begin
                want = pending_tokens.pop_front();
                if (got != want) report("token", got, want);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 3000) begin
            $display("Regression FAIL");
            $finish;
        end
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dtt_pkg.sv
rtl/dtt_fifo.sv
rtl/dtt_scan.sv
rtl/dtt_front.sv
rtl/dsl_text_tokenizer.sv
rtl/dtt_checker.sv
bench/dsl_text_tokenizer_test.sv
